[rtl/core/ppc_pkg.sv]
// package for the planar pixel plot cache
// request/result structs, operation and state codes, tile address function
`default_nettype none
package ppc_pkg;

    localparam int STORE_BYTES_DEF = 131072;
    localparam int CACHE_PIXELS    = 8;
    // wide enough for the largest unreduced tile address plus plane offset
    localparam int WORK_W          = 20;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [7:0]  value;
        logic [16:0] host_address;
    } in_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [7:0] read_data;
    } out_t;

    typedef enum logic [2:0] {
        OP_SET_COLOR  = 3'd0,
        OP_PLOT       = 3'd1,
        OP_READ_PIXEL = 3'd2,
        OP_HOST_WRITE = 3'd3,
        OP_HOST_READ  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CFG_PLOT_OPTIONS  = 2'd0,
        CFG_DEPTH_MODE    = 2'd1,
        CFG_HEIGHT_MODE   = 2'd2,
        CFG_SCREEN_BASE   = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLOT,
        ST_PUT,
        ST_FLUSH,
        ST_BASE_RED,
        ST_PADDR,
        ST_PRED,
        ST_PMOD,
        ST_FDONE,
        ST_RB_ADDR,
        ST_HOST_RED,
        ST_HOST_RD,
        ST_RESULT
    } state_t;

    // why the current flush runs
    typedef enum logic [1:0] {
        PH_ROW,
        PH_FULL,
        PH_RD1,
        PH_RD0
    } phase_t;

    // unreduced tile address; shift is log2 of the bitplane count
    function automatic logic [WORK_W-1:0] tile_addr(
        input logic [7:0] x,
        input logic [7:0] y,
        input logic [1:0] layout,
        input logic [1:0] shift,
        input logic [7:0] sbase
    );
        logic [9:0]        cn;
        logic [WORK_W-1:0] prod;
        cn = '0;
        unique case (layout)
            2'd0: cn = 10'({x[7:3], 4'b0}) + 10'(y[7:3]);
            2'd1: cn = 10'({x[7:3], 4'b0}) + 10'({x[7:3], 2'b0}) + 10'(y[7:3]);
            2'd2: cn = 10'({x[7:3], 4'b0}) + 10'({x[7:3], 3'b0}) + 10'(y[7:3]);
            default: cn = {y[7], 9'b0} + 10'({x[7], 8'b0}) + 10'({y[6:3], 4'b0})
                          + 10'(x[6:3]);
        endcase
        prod = WORK_W'(cn) << (3'(shift) + 3'd3);
        return prod + WORK_W'({sbase, 10'b0}) + WORK_W'({y[2:0], 1'b0});
    endfunction

endpackage
`default_nettype wire

[rtl/core/ppc_store.sv]
// simple dual port bitplane store: one write and one registered read per cycle
// depends on nothing outside this file
`default_nettype none
module ppc_store #(
    parameter int STORE_BYTES = 131072,
    parameter int AW          = $clog2(STORE_BYTES)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);
    logic [7:0] mem [STORE_BYTES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/planar_pixel_plot_cache_top.sv]
// planar pixel plot cache: plot engine, two row cache entries, bitplane store
// depends on ppc_pkg and ppc_store
//
// usage: requests come on s_valid/s_ready/s_data, one result per request on
// m_valid/m_ready/m_data. configuration is written through cfg_we, cfg_index
// and cfg_wdata while the block is idle; writes take effect at once.
// s_ready is high only while the sequencer is idle; one request is worked at
// a time. a plot that hits its row flushes only when it fills the entry;
// each flush of an entry reduces its address and then does one
// read-modify-write per bitplane (P = 2, 4 or 8 bitplanes) on the store.
// read_pixel flushes both entries and then reads P bytes.
// after reset the store is cleared one byte a cycle, all STORE_BYTES bytes, with
// s_ready low; configuration writes are taken during that pass.
// the result register frees the sequencer: a new request is accepted while
// a result waits, and the next result holds until m_ready takes the old one.
`default_nettype none
module planar_pixel_plot_cache_top #(
    parameter int STORE_BYTES = ppc_pkg::STORE_BYTES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_wdata,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ppc_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ppc_pkg::out_t      m_data
);
    import ppc_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [WORK_W-1:0] STORE_LIM = WORK_W'(STORE_BYTES);
    localparam logic [AW-1:0]     CLR_LAST  = AW'(STORE_BYTES - 1);

    state_t            state_reg, state_next;
    phase_t            phase_reg;
    in_t               req_reg;
    logic [4:0]        opts_reg;
    logic [1:0]        depth_reg;
    logic [1:0]        hmode_reg;
    logic [7:0]        sbase_reg;
    logic [7:0]        color_reg;
    logic [12:0]       row_reg  [2];
    logic [7:0]        mask_reg [2];
    logic [7:0]        pix_reg  [2][CACHE_PIXELS];
    logic [WORK_W-1:0] addr_reg;
    logic [WORK_W-1:0] base_reg;
    logic [2:0]        plane_reg;
    logic              ent_reg;
    logic              rb_reg;
    logic [7:0]        acc_reg;
    logic [7:0]        rd_res_reg;
    logic [AW-1:0]     clr_reg;
    logic              m_valid_reg;
    out_t              m_data_reg;

    logic [7:0]  rdata;
    logic        st_we, st_re;
    logic [AW-1:0] st_waddr;
    logic [7:0]  st_wdata;

    logic [1:0]  plane_shift;
    logic [2:0]  plane_top;
    logic        plane_last;
    logic [1:0]  layout;
    logic        md3;
    logic [7:0]  plot_color;
    logic        plot_drop;
    logic [12:0] req_off;
    logic [2:0]  req_slot;
    logic [7:0]  mask0_new;
    logic        addr_big;
    logic [7:0]  gather;
    logic [7:0]  merged;
    logic [12:0] ent_off;

    // plane count and derived values
    always_comb begin
        unique case (depth_reg)
            2'd0:    plane_shift = 2'd1;
            2'd3:    plane_shift = 2'd3;
            default: plane_shift = 2'd2;
        endcase
        plane_top  = 3'((4'd1 << plane_shift) - 4'd1);
        plane_last = (plane_reg == plane_top);
        layout     = opts_reg[4] ? 2'd3 : hmode_reg;
        md3        = (depth_reg == 2'd3);
        addr_big   = (addr_reg >= STORE_LIM);
        ent_off    = row_reg[ent_reg];
    end

    // dither and transparency
    always_comb begin
        plot_color = color_reg;
        if (opts_reg[1] && !md3) begin
            if (req_reg.pixel_x[0] ^ req_reg.pixel_y[0]) begin
                plot_color = color_reg >> 4;
            end
            plot_color = plot_color & 8'h0f;
        end
        if (md3 && !opts_reg[3]) begin
            plot_drop = !opts_reg[0] && (plot_color == 8'd0);
        end else begin
            plot_drop = !opts_reg[0] && (plot_color[3:0] == 4'd0);
        end
        req_off   = {req_reg.pixel_y, req_reg.pixel_x[7:3]};
        req_slot  = ~req_reg.pixel_x[2:0];
        mask0_new = mask_reg[0] | (8'd1 << req_slot);
    end

    // bitplane byte of the flushed entry
    always_comb begin
        for (int s = 0; s < CACHE_PIXELS; s++) begin
            gather[s] = pix_reg[ent_reg][s][plane_reg];
        end
        merged = (gather & mask_reg[ent_reg]) | (rdata & ~mask_reg[ent_reg]);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CLR_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.operation)
                        OP_PLOT:                     state_next = ST_PLOT;
                        OP_READ_PIXEL:               state_next = ST_FLUSH;
                        OP_HOST_WRITE, OP_HOST_READ: state_next = ST_HOST_RED;
                        default:                     state_next = ST_RESULT;
                    endcase
                end
            end
            ST_PLOT: begin
                if (plot_drop)                     state_next = ST_RESULT;
                else if (req_off != row_reg[0])    state_next = ST_FLUSH;
                else                               state_next = ST_PUT;
            end
            ST_PUT: begin
                state_next = (mask0_new == 8'hff) ? ST_FLUSH : ST_RESULT;
            end
            ST_FLUSH: begin
                state_next = (mask_reg[ent_reg] == 8'd0) ? ST_FDONE : ST_BASE_RED;
            end
            ST_BASE_RED: begin
                if (!addr_big) state_next = ST_PADDR;
            end
            ST_PADDR: state_next = ST_PRED;
            ST_PRED: begin
                if (!addr_big) state_next = ST_PMOD;
            end
            ST_PMOD: begin
                if (!plane_last)  state_next = ST_PADDR;
                else if (rb_reg)  state_next = ST_RESULT;
                else              state_next = ST_FDONE;
            end
            ST_FDONE: begin
                unique case (phase_reg)
                    PH_ROW:  state_next = ST_PUT;
                    PH_FULL: state_next = ST_RESULT;
                    PH_RD1:  state_next = ST_FLUSH;
                    default: state_next = ST_RB_ADDR;
                endcase
            end
            ST_RB_ADDR: state_next = ST_BASE_RED;
            ST_HOST_RED: begin
                if (!addr_big) begin
                    state_next = (req_reg.operation == OP_HOST_READ) ? ST_HOST_RD
                                                                     : ST_RESULT;
                end
            end
            ST_HOST_RD: state_next = ST_RESULT;
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // store port control
    always_comb begin
        st_we    = 1'b0;
        st_re    = 1'b0;
        st_waddr = addr_reg[AW-1:0];
        st_wdata = merged;
        unique case (state_reg)
            ST_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = 8'd0;
            end
            ST_PRED: st_re = !addr_big;
            ST_PMOD: st_we = !rb_reg;
            ST_HOST_RED: begin
                st_we    = !addr_big && (req_reg.operation == OP_HOST_WRITE);
                st_re    = !addr_big && (req_reg.operation == OP_HOST_READ);
                st_wdata = req_reg.value;
            end
            default: ;
        endcase
    end

    ppc_store #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (state_reg == ST_RESULT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opts_reg  <= '0;
            depth_reg <= '0;
            hmode_reg <= '0;
            sbase_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PLOT_OPTIONS: opts_reg  <= cfg_wdata[4:0];
                CFG_DEPTH_MODE:   depth_reg <= cfg_wdata[1:0];
                CFG_HEIGHT_MODE:  hmode_reg <= cfg_wdata[1:0];
                default:          sbase_reg <= cfg_wdata;
            endcase
        end
    end

    // cache and sequencer datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= '0;
            for (int e = 0; e < 2; e++) begin
                row_reg[e]  <= '0;
                mask_reg[e] <= '0;
                for (int s = 0; s < CACHE_PIXELS; s++) pix_reg[e][s] <= '0;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_data.operation == OP_SET_COLOR) begin
                        if (opts_reg[2]) begin
                            color_reg <= {color_reg[7:4], s_data.value[7:4]};
                        end else if (opts_reg[3]) begin
                            color_reg <= {color_reg[7:4], s_data.value[3:0]};
                        end else begin
                            color_reg <= s_data.value;
                        end
                    end
                end
                ST_PUT: begin
                    pix_reg[0][req_slot] <= plot_color;
                    mask_reg[0]          <= mask0_new;
                end
                ST_FDONE: begin
                    // retire entry 0 into entry 1, which was just flushed
                    if (phase_reg == PH_ROW || phase_reg == PH_FULL) begin
                        row_reg[1]  <= row_reg[0];
                        mask_reg[1] <= mask_reg[0];
                        for (int s = 0; s < CACHE_PIXELS; s++) begin
                            pix_reg[1][s] <= pix_reg[0][s];
                        end
                        mask_reg[0] <= '0;
                        if (phase_reg == PH_ROW) row_reg[0] <= req_off;
                    end else begin
                        mask_reg[ent_reg] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                req_reg    <= s_data;
                acc_reg    <= '0;
                rd_res_reg <= '0;
                addr_reg   <= WORK_W'(s_data.host_address);
                phase_reg  <= PH_RD1;
                ent_reg    <= 1'b1;
                rb_reg     <= 1'b0;
            end
            ST_PLOT: begin
                phase_reg <= PH_ROW;
                ent_reg   <= 1'b1;
            end
            ST_PUT: begin
                phase_reg <= PH_FULL;
                ent_reg   <= 1'b1;
            end
            ST_FLUSH: begin
                addr_reg <= tile_addr({ent_off[4:0], 3'b0}, ent_off[12:5], layout,
                                      plane_shift, sbase_reg);
                rb_reg   <= 1'b0;
            end
            ST_RB_ADDR: begin
                addr_reg <= tile_addr(req_reg.pixel_x, req_reg.pixel_y, layout,
                                      plane_shift, sbase_reg);
                rb_reg   <= 1'b1;
            end
            ST_BASE_RED: begin
                if (addr_big) begin
                    addr_reg <= addr_reg - STORE_LIM;
                end else begin
                    base_reg  <= addr_reg;
                    plane_reg <= '0;
                end
            end
            ST_PADDR: begin
                addr_reg <= base_reg + WORK_W'({plane_reg[2:1], 3'b000, plane_reg[0]});
            end
            ST_PRED, ST_HOST_RED: begin
                if (addr_big) addr_reg <= addr_reg - STORE_LIM;
            end
            ST_PMOD: begin
                if (rb_reg) acc_reg[plane_reg] <= rdata[~req_reg.pixel_x[2:0]];
                plane_reg <= plane_reg + 3'd1;
            end
            ST_FDONE: begin
                if (phase_reg == PH_RD1) begin
                    phase_reg <= PH_RD0;
                    ent_reg   <= 1'b0;
                end
            end
            ST_HOST_RD: rd_res_reg <= rdata;
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_reg.pixel_value <= acc_reg;
                    m_data_reg.read_data   <= rd_res_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
`default_nettype wire

[rtl/core/ppc_checker.sv]
// port level checks for the planar pixel plot cache, bound to the top level
// depends on ppc_pkg
`default_nettype none
module ppc_port_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire ppc_pkg::out_t m_data
);
    import ppc_pkg::*;

    // store clear pass holds off requests after reset
    a_clear_busy: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("request taken during store clear");

    // one request at a time
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready right after a request");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    // only one of the two result fields can be set by any operation
    a_one_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pixel_value == 8'd0 || m_data.read_data == 8'd0))
        else $error("both result fields nonzero");
endmodule

bind planar_pixel_plot_cache_top ppc_port_checker u_ppc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
